@@ hw/rtl/session_chunk_window_vote_defines.svh @@
// assertion macros for the windowed majority vote labeler
// used by the top level only, no other dependencies
`ifndef SESSION_CHUNK_WINDOW_VOTE_DEFINES_SVH
`define SESSION_CHUNK_WINDOW_VOTE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCWV_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SCWV_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/scwv_pkg.sv @@
// shared constants, codes, structs and helpers of the window vote labeler
// no dependencies
`default_nettype none

package scwv_pkg;

    // sizing
    localparam int NUM_CLASSES     = 16;
    localparam int MAX_WINDOW      = 256;
    localparam int MAX_PREDICTIONS = 32;

    // fixed field widths
    localparam int SESSION_W    = 32;
    localparam int LABEL_W      = 4;
    localparam int SLOT_W       = 5;
    localparam int CHUNK_W      = 14;
    localparam int WIN_FIELD_W  = 9;
    localparam int PRED_FIELD_W = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;

    // derived widths
    localparam int CLASS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
    localparam int PRED_W  = $clog2(MAX_PREDICTIONS + 1);
    localparam int LBUF_W  = (MAX_PREDICTIONS > 1) ? $clog2(MAX_PREDICTIONS) : 1;
    localparam int LIMIT_W = WIN_W + PRED_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN     = 2'd0,
        CFG_PRED_PER_CHUNK = 2'd1,
        CFG_TARGETS_EN     = 2'd2
    } t_cfg_idx;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_VOTE,
        S_EMIT
    } t_state;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [WIN_W-1:0]   window_len;
        logic [PRED_W-1:0]  preds;
        logic               targets_en;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic load;
        logic count;
        logic vote;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_end;
        logic sess_change;
        logic chunk_open;
        logic chunk_full;
        logic out_free;
        logic slot_last;
    } t_status;

    // labels past the last class fold into the last class
    function automatic logic [CLASS_W-1:0] class_of(input logic [LABEL_W-1:0] lbl);
        if (int'(lbl) >= NUM_CLASSES) begin
            class_of = CLASS_W'(NUM_CLASSES - 1);
        end else begin
            class_of = CLASS_W'(lbl);
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scwv_cfg.sv @@
// configuration registers with range clamping and chunk sample limit
// depends on scwv_pkg
`default_nettype none

module scwv_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [scwv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [scwv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output scwv_pkg::t_cfg                   o_cfg
);
    import scwv_pkg::*;

    logic [WIN_W-1:0]        r_window_len, n_window_len;
    logic [PRED_W-1:0]       r_preds, n_preds;
    logic                    r_targets_en;
    logic [WIN_FIELD_W-1:0]  win_raw;
    logic [PRED_FIELD_W-1:0] pred_raw;

    assign o_cfg_ready = 1'b1;
    assign win_raw     = i_cfg_data[WIN_FIELD_W-1:0];
    assign pred_raw    = i_cfg_data[PRED_FIELD_W-1:0];

    // clamp written values into their legal ranges
    always_comb begin
        if (win_raw == '0) begin
            n_window_len = WIN_W'(1);
        end else if (int'(win_raw) > MAX_WINDOW) begin
            n_window_len = WIN_W'(MAX_WINDOW);
        end else begin
            n_window_len = WIN_W'(win_raw);
        end
        if (pred_raw == '0) begin
            n_preds = PRED_W'(1);
        end else if (int'(pred_raw) > MAX_PREDICTIONS) begin
            n_preds = PRED_W'(MAX_PREDICTIONS);
        end else begin
            n_preds = PRED_W'(pred_raw);
        end
    end

    // register write decode, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WIN_W'(1);
            r_preds      <= PRED_W'(1);
            r_targets_en <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_LEN:     r_window_len <= n_window_len;
                CFG_PRED_PER_CHUNK: r_preds      <= n_preds;
                CFG_TARGETS_EN:     r_targets_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // samples per full chunk
    assign o_cfg.window_len = r_window_len;
    assign o_cfg.preds      = r_preds;
    assign o_cfg.targets_en = r_targets_en;
    assign o_cfg.limit      = LIMIT_W'(r_window_len) * LIMIT_W'(r_preds);

endmodule

`default_nettype wire

@@ hw/rtl/scwv_ctrl.sv @@
// controller state machine: sample count, close vote and slot emission
// depends on scwv_pkg
`default_nettype none

module scwv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  scwv_pkg::t_status i_status,
    output scwv_pkg::t_cmd    o_cmd
);
    import scwv_pkg::*;

    t_state r_state, n_state;
    logic   r_resume, n_resume;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resume <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_end) begin
                        n_resume = 1'b0;
                        n_state  = i_status.chunk_open ? S_VOTE : S_IDLE;
                    end else if (i_status.sess_change && i_status.chunk_open) begin
                        // close the old session's chunk, then count the sample
                        n_resume = 1'b1;
                        n_state  = S_VOTE;
                    end else begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                n_resume = 1'b0;
                n_state  = i_status.chunk_full ? S_VOTE : S_IDLE;
            end
            S_VOTE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free && i_status.slot_last) begin
                    n_state = r_resume ? S_COUNT : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.take  = (r_state == S_IDLE);
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.count = (r_state == S_COUNT);
        o_cmd.vote  = (r_state == S_VOTE);
        o_cmd.emit  = (r_state == S_EMIT) && i_status.out_free;
    end

endmodule

`default_nettype wire

@@ hw/rtl/scwv_dp.sv @@
// datapath: class histogram with running majority, label buffer, chunk
// counters and the output register; depends on scwv_pkg
`default_nettype none

module scwv_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  scwv_pkg::t_cmd                  i_cmd,
    input  scwv_pkg::t_cfg                  i_cfg,
    input  logic                            i_operation,
    input  logic [scwv_pkg::SESSION_W-1:0]  i_session_tag,
    input  logic [scwv_pkg::LABEL_W-1:0]    i_class_label,
    input  logic                            i_out_stall,
    output scwv_pkg::t_status               o_status,
    output logic                            o_out_valid,
    output logic [scwv_pkg::LABEL_W-1:0]    o_label_value,
    output logic                            o_slot_weight,
    output logic [scwv_pkg::SLOT_W-1:0]     o_slot_index,
    output logic [scwv_pkg::SESSION_W-1:0]  o_chunk_session,
    output logic [scwv_pkg::CHUNK_W-1:0]    o_chunk_samples,
    output logic                            o_last_in_chunk
);
    import scwv_pkg::*;

    // histogram and running majority of the open window
    logic [WIN_W-1:0]     r_hist [NUM_CLASSES];
    logic [WIN_W-1:0]     r_window_fill;
    logic [CLASS_W-1:0]   r_best;
    logic [WIN_W-1:0]     r_best_cnt;
    // chunk state
    logic [LIMIT_W-1:0]   r_chunk_fill;
    logic [LABEL_W-1:0]   r_lbuf [MAX_PREDICTIONS];
    logic [PRED_W-1:0]    r_labels_held;
    logic [SESSION_W-1:0] r_last_session;
    logic [PRED_W-1:0]    r_slot;
    // latched sample
    logic [SESSION_W-1:0] r_in_session;
    logic [CLASS_W-1:0]   r_in_class;
    // output register
    logic                 r_out_valid;
    logic [LABEL_W-1:0]   r_label_value;
    logic                 r_slot_weight;
    logic [SLOT_W-1:0]    r_slot_index;
    logic [SESSION_W-1:0] r_chunk_session;
    logic [CHUNK_W-1:0]   r_chunk_samples;
    logic                 r_last_in_chunk;

    logic [WIN_W-1:0]     hist_inc;
    logic [WIN_W-1:0]     wfill_inc;
    logic [CLASS_W-1:0]   n_best;
    logic [WIN_W-1:0]     n_best_cnt;
    logic                 window_done;
    logic                 can_store;
    logic                 count_vote;
    logic                 close_vote;
    logic                 store_label;
    logic                 clear_win;
    logic                 chunk_done;
    logic [CLASS_W-1:0]   vote_label;
    logic [LIMIT_W-1:0]   chunk_inc;
    logic [PRED_W-1:0]    num_slots;
    logic [PRED_W-1:0]    slot_inc;
    logic                 slot_last;
    logic                 slot_real;

    // running majority: counts only grow by one, ties go to the lower class
    assign hist_inc  = r_hist[r_in_class] + WIN_W'(1);
    assign wfill_inc = r_window_fill + WIN_W'(1);

    always_comb begin
        n_best     = r_best;
        n_best_cnt = r_best_cnt;
        if (r_in_class == r_best) begin
            n_best_cnt = hist_inc;
        end else if ((hist_inc > r_best_cnt) ||
                     ((hist_inc == r_best_cnt) && (r_in_class < r_best))) begin
            n_best     = r_in_class;
            n_best_cnt = hist_inc;
        end
    end

    // window close and label store decisions
    assign window_done = (wfill_inc >= i_cfg.window_len);
    assign can_store   = (r_labels_held < i_cfg.preds) &&
                         (int'(r_labels_held) < MAX_PREDICTIONS);
    assign count_vote  = i_cmd.count && i_cfg.targets_en && window_done;
    assign close_vote  = i_cmd.vote && i_cfg.targets_en && (r_window_fill != '0);
    assign store_label = (count_vote || close_vote) && can_store;
    assign vote_label  = i_cmd.count ? n_best : r_best;

    // slot walk
    assign chunk_inc  = r_chunk_fill + LIMIT_W'(1);
    assign num_slots  = i_cfg.targets_en ? i_cfg.preds : PRED_W'(1);
    assign slot_inc   = r_slot + PRED_W'(1);
    assign slot_last  = (slot_inc == num_slots);
    assign slot_real  = i_cfg.targets_en && (r_slot < r_labels_held);
    assign chunk_done = i_cmd.emit && slot_last;
    assign clear_win  = count_vote || close_vote || chunk_done;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist         <= '{default: '0};
            r_window_fill  <= '0;
            r_best         <= '0;
            r_best_cnt     <= '0;
            r_chunk_fill   <= '0;
            r_labels_held  <= '0;
            r_last_session <= '0;
            r_slot         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // output register handshake
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // histogram and window fill
            if (clear_win) begin
                r_hist        <= '{default: '0};
                r_window_fill <= '0;
                r_best        <= '0;
                r_best_cnt    <= '0;
            end else if (i_cmd.count && i_cfg.targets_en) begin
                r_hist[r_in_class] <= hist_inc;
                r_window_fill      <= wfill_inc;
                r_best             <= n_best;
                r_best_cnt         <= n_best_cnt;
            end

            // chunk fill and session
            if (chunk_done) begin
                r_chunk_fill <= '0;
            end else if (i_cmd.count) begin
                r_chunk_fill <= chunk_inc;
            end
            if (i_cmd.count) begin
                r_last_session <= r_in_session;
            end

            // labels held
            if (chunk_done) begin
                r_labels_held <= '0;
            end else if (store_label) begin
                r_labels_held <= r_labels_held + PRED_W'(1);
            end

            // slot counter
            if (i_cmd.vote) begin
                r_slot <= '0;
            end else if (i_cmd.emit) begin
                r_slot <= slot_inc;
            end
        end
    end

    // label buffer, read only below the held count
    always_ff @(posedge i_clk) begin
        if (store_label) begin
            r_lbuf[r_labels_held[LBUF_W-1:0]] <= LABEL_W'(vote_label);
        end
    end

    // sample latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_session <= i_session_tag;
            r_in_class   <= class_of(i_class_label);
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_label_value   <= slot_real ? r_lbuf[r_slot[LBUF_W-1:0]] : '0;
            r_slot_weight   <= slot_real;
            r_slot_index    <= SLOT_W'(r_slot);
            r_chunk_session <= r_last_session;
            r_chunk_samples <= CHUNK_W'(r_chunk_fill);
            r_last_in_chunk <= slot_last;
        end
    end

    // status to the controller
    assign o_status.in_end      = i_operation;
    assign o_status.sess_change = (i_session_tag != r_last_session);
    assign o_status.chunk_open  = (r_chunk_fill != '0);
    assign o_status.chunk_full  = (chunk_inc >= i_cfg.limit);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;
    assign o_status.slot_last   = slot_last;

    assign o_out_valid     = r_out_valid;
    assign o_label_value   = r_label_value;
    assign o_slot_weight   = r_slot_weight;
    assign o_slot_index    = r_slot_index;
    assign o_chunk_session = r_chunk_session;
    assign o_chunk_samples = r_chunk_samples;
    assign o_last_in_chunk = r_last_in_chunk;

endmodule

`default_nettype wire

@@ hw/rtl/session_chunk_window_vote.sv @@
// top level of the windowed majority vote labeler
// depends on scwv_pkg, scwv_cfg, scwv_ctrl, scwv_dp and the assertion macro header
//
//   channel   direction  handshake               payload
//   in        sink       i_in_valid / o_in_stall  operation, session_tag, class_label
//   out       source     o_out_valid / i_out_stall label_value, slot_weight, slot_index,
//                                                  chunk_session, chunk_samples, last_in_chunk
//   cfg       sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
// a sample is accepted, then counted by one histogram update in the datapath
// a chunk close adds a vote step, then emits its slots one by one (predictions
// per chunk, or 1 without targets), each slot waiting while the output stalls
// a session change that closes a chunk runs the close, then the sample's histogram update
// reset is synchronous, active low, and needs no clearing pass
// the output register holds a result while the next item is taken in
`default_nettype none
`include "session_chunk_window_vote_defines.svh"

module session_chunk_window_vote (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [scwv_pkg::SESSION_W-1:0]  i_session_tag,
    input  logic [scwv_pkg::LABEL_W-1:0]    i_class_label,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [scwv_pkg::LABEL_W-1:0]    o_label_value,
    output logic                            o_slot_weight,
    output logic [scwv_pkg::SLOT_W-1:0]     o_slot_index,
    output logic [scwv_pkg::SESSION_W-1:0]  o_chunk_session,
    output logic [scwv_pkg::CHUNK_W-1:0]    o_chunk_samples,
    output logic                            o_last_in_chunk,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scwv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scwv_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scwv_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    // configuration registers
    scwv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // controller
    scwv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    scwv_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .i_operation     (i_operation),
        .i_session_tag   (i_session_tag),
        .i_class_label   (i_class_label),
        .i_out_stall     (i_out_stall),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_label_value   (o_label_value),
        .o_slot_weight   (o_slot_weight),
        .o_slot_index    (o_slot_index),
        .o_chunk_session (o_chunk_session),
        .o_chunk_samples (o_chunk_samples),
        .o_last_in_chunk (o_last_in_chunk)
    );

    assign o_in_stall = !cmd.take;

    // an accepted sample always makes the block busy, stalling the input, before it takes another item
    `SCWV_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_operation, o_in_stall, "sample accepted without a busy cycle")

    // the last slot of a close leaves the chunk empty
    `SCWV_ASSERT_NEXT(a_close_clears_chunk, i_clk, i_rst_n, cmd.emit && status.slot_last, !status.chunk_open, "chunk still open after its last slot")

    // a result only appears after a slot load
    `SCWV_ASSERT_NOW(a_valid_from_emit, i_clk, i_rst_n, $rose(o_out_valid), $past(cmd.emit), "result valid without a slot load")

endmodule

`default_nettype wire

@@ tb/sv/session_chunk_window_vote_tb.sv @@
// self-checking testbench for the windowed majority vote labeler
// drives random and directed sample items, predicts every chunk slot and compares
// depends on scwv_pkg and the session_chunk_window_vote top level
`default_nettype none

module session_chunk_window_vote_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scwv_pkg::*;

    // item operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_END    = 1'b1;

    // register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;

    typedef enum logic [1:0] {
        FLOW_OPEN,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_TOGGLE
    } t_flow;

    typedef struct {
        logic                 op;
        logic [SESSION_W-1:0] session;
        logic [LABEL_W-1:0]   label;
    } t_sample;

    typedef struct {
        logic [LABEL_W-1:0]   label;
        logic                 weight;
        logic [SLOT_W-1:0]    slot;
        logic [SESSION_W-1:0] session;
        logic [CHUNK_W-1:0]   samples;
        logic                 last;
    } t_slot;

    // block ports
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation   = OP_SAMPLE;
    logic [SESSION_W-1:0]  i_session_tag = '0;
    logic [LABEL_W-1:0]    i_class_label = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [LABEL_W-1:0]    o_label_value;
    logic                  o_slot_weight;
    logic [SLOT_W-1:0]     o_slot_index;
    logic [SESSION_W-1:0]  o_chunk_session;
    logic [CHUNK_W-1:0]    o_chunk_samples;
    logic                  o_last_in_chunk;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // stimulus and expected slots
    t_sample sample_queue[$];
    t_slot   pending_slots[$];
    int      fail_count = 0;

    // predicted configuration, reset values
    logic [8:0] win_len    = 9'd1;
    logic [5:0] slot_count = 6'd1;
    logic       use_tgt    = 1'b1;

    // predicted vote state, reset values
    logic [8:0]         hist [NUM_CLASSES]         = '{default: '0};
    logic [8:0]         win_fill                   = '0;
    logic [CHUNK_W-1:0] chunk_fill                 = '0;
    logic [LABEL_W-1:0] label_buf [MAX_PREDICTIONS] = '{default: '0};
    logic [5:0]         labels_held                = '0;
    logic [SESSION_W-1:0] last_sess                = '0;

    // sender and receiver pacing
    int    burst_left = 0;
    int    gap_left   = 0;
    t_flow flow_mode  = FLOW_OPEN;
    int    flow_left  = 0;
    int    hold_left  = 0;
    logic  hold_req   = 1'b0;
    logic  hold_done  = 1'b0;
    int    idle_cycles = 0;

    session_chunk_window_vote dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_session_tag   (i_session_tag),
        .i_class_label   (i_class_label),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_label_value   (o_label_value),
        .o_slot_weight   (o_slot_weight),
        .o_slot_index    (o_slot_index),
        .o_chunk_session (o_chunk_session),
        .o_chunk_samples (o_chunk_samples),
        .o_last_in_chunk (o_last_in_chunk),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // register write as the block decodes it
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        int v;
        case (idx)
            CFG_WINDOW_LEN: begin
                v = int'(data);
                if (v < 1) v = 1;
                if (v > MAX_WINDOW) v = MAX_WINDOW;
                win_len = 9'(v);
            end
            CFG_PRED_PER_CHUNK: begin
                v = int'(data[5:0]);
                if (v < 1) v = 1;
                if (v > MAX_PREDICTIONS) v = MAX_PREDICTIONS;
                slot_count = 6'(v);
            end
            CFG_TARGETS_EN: begin
                use_tgt = data[0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void clear_histogram();
        for (int c = 0; c < NUM_CLASSES; c++) hist[c] = '0;
        win_fill = '0;
    endfunction

    // majority of the open window, ties to the lowest class
    function automatic void vote_window();
        int best;
        best = 0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (hist[c] > hist[best]) best = c;
        end
        if (labels_held < slot_count && labels_held < MAX_PREDICTIONS) begin
            label_buf[labels_held] = LABEL_W'(best);
            labels_held++;
        end
        clear_histogram();
    endfunction

    // queue the slots a chunk close emits
    function automatic void emit_chunk(input logic [SESSION_W-1:0] sess);
        t_slot r;
        r.session = sess;
        r.samples = chunk_fill;
        if (use_tgt) begin
            if (win_fill != 0) vote_window();
            for (int s = 0; s < slot_count; s++) begin
                r.weight = (s < labels_held);
                r.label  = r.weight ? label_buf[s] : '0;
                r.slot   = SLOT_W'(s);
                r.last   = (s + 1 == slot_count);
                pending_slots = {pending_slots, r};
            end
        end else begin
            r.label  = '0;
            r.weight = 1'b0;
            r.slot   = '0;
            r.last   = 1'b1;
            pending_slots = {pending_slots, r};
        end
        clear_histogram();
        chunk_fill  = '0;
        labels_held = '0;
    endfunction

    // advance the predicted labeler by one accepted item
    function automatic void track_sample(input logic op, input logic [SESSION_W-1:0] sess,
                                         input logic [LABEL_W-1:0] lbl);
        int cls;
        if (op == OP_END) begin
            if (chunk_fill != 0) emit_chunk(last_sess);
        end else begin
            if (sess != last_sess) begin
                if (chunk_fill != 0) emit_chunk(last_sess);
                last_sess = sess;
            end
            chunk_fill++;
            if (use_tgt) begin
                cls = (int'(lbl) >= NUM_CLASSES) ? NUM_CLASSES - 1 : int'(lbl);
                hist[cls]++;
                win_fill++;
                if (win_fill >= win_len) vote_window();
            end
            if (int'(chunk_fill) >= int'(win_len) * int'(slot_count)) emit_chunk(sess);
        end
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10) $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic add_sample(input logic op, input logic [SESSION_W-1:0] sess,
                              input logic [LABEL_W-1:0] lbl);
        t_sample it;
        it.op      = op;
        it.session = sess;
        it.label   = lbl;
        sample_queue = {sample_queue, it};
    endtask

    // wait until every item went in and every slot came out, then let the block settle
    task automatic wait_drained();
        while (sample_queue.size() != 0 || i_in_valid || pending_slots.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender: items in bursts with random gaps
    always @(posedge i_clk) begin : drive_proc
        t_sample nxt;
        logic    busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                track_sample(i_operation, i_session_tag, i_class_label);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    nxt = sample_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_operation   <= nxt.op;
                    i_session_tag <= nxt.session;
                    i_class_label <= nxt.label;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        if ($urandom_range(0, 2) == 0) gap_left <= 0;
                        else if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(15, 40);
                        else gap_left <= $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern that changes mode, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            flow_mode   <= FLOW_OPEN;
            flow_left   <= 0;
            hold_left   <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (flow_left == 0) begin
                flow_mode <= t_flow'($urandom_range(0, 3));
                flow_left <= $urandom_range(16, 80);
            end else begin
                flow_left <= flow_left - 1;
            end
            case (flow_mode)
                FLOW_OPEN:   i_out_stall <= 1'b0;
                FLOW_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                FLOW_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // compare each accepted slot with the oldest prediction
    always @(posedge i_clk) begin : check_proc
        t_slot want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_slots.size() == 0) begin
                note_failure($sformatf("unexpected slot %0d session %h samples %0d",
                                       o_slot_index, o_chunk_session, o_chunk_samples));
            end else begin
                want = pending_slots.pop_front();
                if (o_label_value !== want.label || o_slot_weight !== want.weight ||
                    o_slot_index !== want.slot || o_chunk_session !== want.session ||
                    o_chunk_samples !== want.samples || o_last_in_chunk !== want.last) begin
                    note_failure($sformatf({
                        "slot mismatch exp lbl %0d w %0d idx %0d sess %h n %0d last %0d",
                        " got lbl %0d w %0d idx %0d sess %h n %0d last %0d"},
                        want.label, want.weight, want.slot, want.session, want.samples,
                        want.last, o_label_value, o_slot_weight, o_slot_index,
                        o_chunk_session, o_chunk_samples, o_last_in_chunk));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("session_chunk_window_vote test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus_proc
        logic [SESSION_W-1:0]  sa, sb, cur_sess;
        logic [SESSION_W-1:0]  pool [3];
        logic [LABEL_W-1:0]    fav_a, fav_b, lbl;
        logic [CFG_DATA_W-1:0] wl_data, ppc_data;
        logic                  ut;
        int                    run_left, n_items;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every sample closes a one-slot chunk
        add_sample(OP_SAMPLE, '0, 4'd0);
        add_sample(OP_SAMPLE, '1, 4'd15);
        // end of data on an empty chunk
        add_sample(OP_END, '0, 4'd0);
        wait_drained();

        // three-sample windows, two per chunk
        write_reg(CFG_WINDOW_LEN, 9'd3);
        write_reg(CFG_PRED_PER_CHUNK, 9'd2);
        sa = $urandom;
        sb = ~sa;
        add_sample(OP_SAMPLE, sa, 4'd7);
        add_sample(OP_SAMPLE, sa, 4'd2);
        add_sample(OP_SAMPLE, sa, 4'd2);
        // three-way tie goes to the lowest class, chunk full
        add_sample(OP_SAMPLE, sa, 4'd9);
        add_sample(OP_SAMPLE, sa, 4'd4);
        add_sample(OP_SAMPLE, sa, 4'd1);
        // session change closes a partial window and pads the chunk
        add_sample(OP_SAMPLE, sa, 4'd5);
        add_sample(OP_SAMPLE, sa, 4'd5);
        add_sample(OP_SAMPLE, sb, 4'd3);
        add_sample(OP_END, sa, 4'd11);
        wait_drained();

        // saturated registers: 256-sample windows, 32 slots
        write_reg(CFG_WINDOW_LEN, 9'h1FF);
        write_reg(CFG_PRED_PER_CHUNK, 9'd63);
        add_sample(OP_SAMPLE, sa, 4'd8);
        add_sample(OP_SAMPLE, sa, 4'd8);
        add_sample(OP_END, sb, 4'd0);
        wait_drained();

        // zero registers act as one, records without targets, undecoded index
        write_reg(CFG_WINDOW_LEN, 9'd0);
        write_reg(CFG_PRED_PER_CHUNK, 9'h040);
        write_reg(CFG_TARGETS_EN, 9'h0FE);
        write_reg(CFG_UNUSED_IDX, 9'h1FF);
        add_sample(OP_SAMPLE, sb, 4'd6);
        wait_drained();

        // records without targets closed by session change and end of data
        write_reg(CFG_WINDOW_LEN, 9'd4);
        write_reg(CFG_PRED_PER_CHUNK, 9'd3);
        add_sample(OP_SAMPLE, sa, 4'd1);
        add_sample(OP_SAMPLE, sa, 4'd14);
        add_sample(OP_SAMPLE, sb, 4'd13);
        add_sample(OP_END, sa, 4'd0);
        wait_drained();

        // registers changed with a window open: overfull window votes on next sample
        write_reg(CFG_TARGETS_EN, 9'h001);
        write_reg(CFG_PRED_PER_CHUNK, 9'd2);
        add_sample(OP_SAMPLE, sa, 4'd10);
        add_sample(OP_SAMPLE, sa, 4'd10);
        add_sample(OP_SAMPLE, sa, 4'd3);
        wait_drained();
        write_reg(CFG_WINDOW_LEN, 9'd2);
        add_sample(OP_SAMPLE, sa, 4'd3);

        // random phases, each with its own settings and session runs
        for (int p = 0; p < 9; p++) begin
            if (p == 0) begin
                wl_data = 9'd1;
                ppc_data = 9'd32;
                ut = 1'b1;
            end else if (p == 2) begin
                wl_data = 9'd256;
                ppc_data = 9'd1;
                ut = 1'b1;
            end else if (p == 3) begin
                wl_data = 9'd1;
                ppc_data = 9'd1;
                ut = 1'b1;
            end else if (p == 4) begin
                wl_data = 9'($urandom_range(2, 5));
                ppc_data = 9'($urandom_range(2, 4));
                ut = 1'b0;
            end else begin
                wl_data = 9'($urandom_range(1, 6));
                ppc_data = {3'($urandom), 6'($urandom_range(1, 8))};
                ut = ($urandom_range(0, 3) != 0);
            end
            wait_drained();
            write_reg(CFG_WINDOW_LEN, wl_data);
            write_reg(CFG_PRED_PER_CHUNK, ppc_data);
            write_reg(CFG_TARGETS_EN, {8'($urandom), ut});

            for (int k = 0; k < 3; k++) pool[k] = $urandom;
            fav_a = $urandom;
            fav_b = $urandom;
            run_left = 0;
            cur_sess = pool[0];
            n_items = (p == 3) ? 40 : 22;
            for (int k = 0; k < n_items; k++) begin
                if (run_left == 0) begin
                    cur_sess = pool[$urandom_range(0, 2)];
                    run_left = $urandom_range(1, 12);
                end
                run_left--;
                lbl = ($urandom_range(0, 4) < 3) ?
                      (($urandom_range(0, 1) == 0) ? fav_a : fav_b) : LABEL_W'($urandom);
                if ($urandom_range(0, 19) == 0) add_sample(OP_END, $urandom, lbl);
                else add_sample(OP_SAMPLE, cur_sess, lbl);
            end
            // hold the output off while the sender keeps offering
            if (p == 3) hold_req <= 1'b1;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("session_chunk_window_vote test passed");
        end else begin
            $display("session_chunk_window_vote test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
